// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RSV      = 2'd1;
  localparam logic [1:0] ERR_OPCODE   = 2'd2;
  localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

  // header field masks and length codes
  localparam logic [7:0] HDR_FIN_MASK = 8'h80;
  localparam logic [7:0] HDR_RSV_MASK = 8'h70;
  localparam logic [7:0] HDR_OPC_MASK = 8'h0F;
  localparam logic [7:0] LEN_CODE_MASK = 8'h7F;
  localparam logic [6:0] LEN_CODE_16  = 7'h7E;
  localparam logic [6:0] LEN_CODE_64  = 7'h7F;

  localparam int unsigned MAX_LEN_W = 63;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = {MAX_LEN_W{1'b1}};

  // one result word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_flag;
    logic       last_of_frame;
    logic [1:0] error_code;
  } wsd_res_t;

  // input stage to parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } wsd_byte_t;

  function automatic logic opcode_ok(input logic [3:0] op);
    opcode_ok = (op <= 4'd2) || ((op >= 4'd8) && (op <= 4'd10));
  endfunction

endpackage

// ===== rtl/wsd_in_reg.sv =====
module wsd_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_stream_byte,
  input  logic                room,
  output wsd_pkg::wsd_byte_t  byte_q
);

  logic       vld_r;
  logic [7:0] data_r;

  // hold the word while the parser cannot take it
  assign in_stall = vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_stream_byte;
    end
  end

  assign byte_q.valid = vld_r;
  assign byte_q.data  = data_r;

endmodule

// ===== rtl/wsd_parser.sv =====
module wsd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          b,
  input  logic                cfg_wr_en,
  input  logic [wsd_pkg::MAX_LEN_W-1:0] cfg_wr_data,
  output logic                res_valid,
  output wsd_pkg::wsd_res_t   res
);

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic        fin_r, fin_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [wsd_pkg::MAX_LEN_W-1:0] max_len_r;

  logic        len_done;
  logic [63:0] len_val;
  logic [3:0]  hop;
  logic        hfin;
  logic [7:0]  key_byte;
  logic        last;
  logic [6:0]  code;

  assign hop      = b[3:0];
  assign hfin     = |(b & wsd_pkg::HDR_FIN_MASK);
  assign code     = b[6:0];
  assign key_byte = key_r[{~idx_r, 3'b000} +: 8];
  assign last     = (rem_r <= 64'd1);

  // next state and result for one byte
  always_comb begin
    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    fin_nxt   = fin_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    len_done  = 1'b0;
    len_val   = 64'd0;
    res_valid = 1'b0;
    res       = '0;
    if (adv) begin
      case (phase_r)
        PH_HDR0: begin
          if (|(b & wsd_pkg::HDR_RSV_MASK)) begin
            res_valid        = 1'b1;
            res.kind         = wsd_pkg::KIND_ERROR;
            res.frame_opcode = hop;
            res.final_flag   = hfin;
            res.error_code   = wsd_pkg::ERR_RSV;
          end else if (!wsd_pkg::opcode_ok(hop)) begin
            res_valid        = 1'b1;
            res.kind         = wsd_pkg::KIND_ERROR;
            res.frame_opcode = hop;
            res.final_flag   = hfin;
            res.error_code   = wsd_pkg::ERR_OPCODE;
          end else begin
            opc_nxt   = hop;
            fin_nxt   = hfin;
            idx_nxt   = 2'd0;
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          mask_nxt = b[7];
          rem_nxt  = 64'd0;
          if (code < wsd_pkg::LEN_CODE_16) begin
            len_done = 1'b1;
            len_val  = {57'd0, code};
          end else begin
            cnt_nxt   = (code == wsd_pkg::LEN_CODE_64) ? 4'd8 : 4'd2;
            phase_nxt = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          rem_nxt = {rem_r[55:0], b};
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_nxt == 4'd0) begin
            len_done = 1'b1;
            len_val  = {rem_r[55:0], b};
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], b};
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_nxt == 4'd0) begin
            idx_nxt = 2'd0;
            if (rem_r == 64'd0) begin
              phase_nxt         = PH_HDR0;
              res_valid         = 1'b1;
              res.kind          = wsd_pkg::KIND_EMPTY;
              res.frame_opcode  = opc_r;
              res.final_flag    = fin_r;
              res.last_of_frame = 1'b1;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          idx_nxt = idx_r + 2'd1;
          if (rem_r != 64'd0) begin
            rem_nxt = rem_r - 64'd1;
          end
          if (last) begin
            phase_nxt = PH_HDR0;
          end
          res_valid         = 1'b1;
          res.kind          = wsd_pkg::KIND_PAYLOAD;
          res.payload_byte  = b ^ key_byte;
          res.frame_opcode  = opc_r;
          res.final_flag    = fin_r;
          res.last_of_frame = last;
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // payload length complete: limit check, then key, body or an empty-frame result
      if (len_done) begin
        rem_nxt = len_val;
        if (len_val > {1'b0, max_len_r}) begin
          phase_nxt        = PH_HDR0;
          res_valid        = 1'b1;
          res.kind         = wsd_pkg::KIND_ERROR;
          res.frame_opcode = opc_r;
          res.final_flag   = fin_r;
          res.error_code   = wsd_pkg::ERR_TOO_BIG;
        end else if (mask_nxt) begin
          phase_nxt = PH_KEY;
          cnt_nxt   = 4'd4;
          key_nxt   = 32'd0;
        end else begin
          key_nxt = 32'd0;
          if (len_val == 64'd0) begin
            phase_nxt         = PH_HDR0;
            res_valid         = 1'b1;
            res.kind          = wsd_pkg::KIND_EMPTY;
            res.frame_opcode  = opc_r;
            res.final_flag    = fin_r;
            res.last_of_frame = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      opc_r     <= 4'd0;
      fin_r     <= 1'b0;
      mask_r    <= 1'b0;
      cnt_r     <= 4'd0;
      rem_r     <= 64'd0;
      key_r     <= 32'd0;
      idx_r     <= 2'd0;
      max_len_r <= wsd_pkg::MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      fin_r   <= fin_nxt;
      mask_r  <= mask_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      key_r   <= key_nxt;
      idx_r   <= idx_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== rtl/wsd_out_buf.sv =====
module wsd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wsd_pkg::wsd_res_t  push_res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output wsd_pkg::wsd_res_t  head
);

  logic              head_v_r;
  logic              skid_v_r;
  wsd_pkg::wsd_res_t head_r;
  wsd_pkg::wsd_res_t skid_r;
  logic              pop;

  assign pop       = head_v_r && !out_stall;
  assign room      = !skid_v_r;
  assign out_valid = head_v_r;
  assign head      = head_r;

  // valid bits: head register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        head_v_r <= push;
      end
    end else if (push) begin
      if (head_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        head_v_r <= 1'b1;
      end
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        head_r <= skid_r;
      end else if (push) begin
        head_r <= push_res;
      end
    end else if (push) begin
      if (head_v_r) begin
        skid_r <= push_res;
      end else begin
        head_r <= push_res;
      end
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket receive deframer, one stream byte per word.
// A byte's result passes the input register and the parse step into the
// result buffer's head. Throughput: one byte per cycle while the buffer has
// room, set by the single parse step before the two-entry result buffer.
// Reset: synchronous active-low rst_n; parser waits for a first header byte,
// length limit returns to its maximum, buffers empty.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_final_flag,
  output logic        out_last_of_frame,
  output logic [1:0]  out_error_code,
  input  logic        cfg_wr_en,
  input  logic [wsd_pkg::MAX_LEN_W-1:0] cfg_wr_data
);

  wsd_pkg::wsd_byte_t byte_q;
  wsd_pkg::wsd_res_t  res;
  wsd_pkg::wsd_res_t  head;
  logic               res_valid;
  logic               room;
  logic               adv;

  assign adv = byte_q.valid && room;

  wsd_in_reg u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .room           (room),
    .byte_q         (byte_q)
  );

  wsd_parser u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .b           (byte_q.data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind          = head.kind;
  assign out_payload_byte  = head.payload_byte;
  assign out_frame_opcode  = head.frame_opcode;
  assign out_final_flag    = head.final_flag;
  assign out_last_of_frame = head.last_of_frame;
  assign out_error_code    = head.error_code;

endmodule
